### src/ihc_pkg.sv
package ihc_pkg;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_VERSION  = 3'd1;
   localparam logic [2:0] ST_HEADLEN  = 3'd2;
   localparam logic [2:0] ST_TTL      = 3'd3;
   localparam logic [2:0] ST_CHECKSUM = 3'd4;
   localparam logic [2:0] ST_DEST     = 3'd5;

   localparam logic [7:0]  VER_IHL    = 8'h45;
   localparam logic [3:0]  IP_VERSION = 4'd4;
   localparam logic [3:0]  MIN_IHL    = 4'd5;
   localparam logic [15:0] HDR_BYTES  = 16'd20;
   localparam logic [31:0] BCAST_MASK = 32'h00ff_ffff;
   localparam logic [15:0] CSUM_ONES  = 16'hffff;

   localparam int NUM_LANES = 5;

   typedef struct packed {
      logic        func;
      logic [31:0] hdr_word0;
      logic [31:0] hdr_word1;
      logic [31:0] hdr_word2;
      logic [31:0] hdr_word3;
      logic [31:0] hdr_word4;
      logic [15:0] packet_length;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [7:0]  protocol;
      logic [7:0]  ttl;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [5:0]  payload_offset;
      logic [15:0] payload_length;
      logic [31:0] out_word0;
      logic [31:0] out_word1;
      logic [31:0] out_word2;
      logic [31:0] out_word3;
      logic [31:0] out_word4;
   } rsp_type;

   typedef struct packed {
      logic        func;
      logic [2:0]  pre_status;
      logic        dest_bad;
      logic [5:0]  payload_offset;
      logic [15:0] payload_length;
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
      logic [31:0] word4;
   } side_type;

endpackage

### src/ihc_lane.sv
module ihc_lane (
   input  logic        clock,
   input  logic [31:0] word,
   output logic [16:0] sum
);

   logic [16:0] sum_ff;
   logic [16:0] sum_in;

   assign sum_in = {1'b0, word[31:16]} + {1'b0, word[15:0]};

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
   end

   assign sum = sum_ff;

endmodule

### src/ihc_merge.sv
module ihc_merge (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid,
   input  logic [16:0]         lane_sum [ihc_pkg::NUM_LANES],
   input  ihc_pkg::side_type   side,
   output logic                rsp_valid,
   output ihc_pkg::rsp_type    rsp_data
);

   logic             valid_ff;
   logic             valid_in;
   ihc_pkg::rsp_type data_ff;
   ihc_pkg::rsp_type data_in;

   logic [19:0] total;
   logic [16:0] fold1;
   logic [16:0] fold2;
   logic [15:0] csum;

   always_comb begin
      total = 20'd0;
      for (int i = 0; i < ihc_pkg::NUM_LANES; i++) begin
         total = total + {3'b000, lane_sum[i]};
      end
      fold1 = {13'd0, total[19:16]} + {1'b0, total[15:0]};
      fold2 = {16'd0, fold1[16]} + {1'b0, fold1[15:0]};
      csum  = ~fold2[15:0];
   end

   always_comb begin
      data_in = '0;
      if (side.func) begin
         data_in.out_word0 = side.word0;
         data_in.out_word1 = side.word1;
         data_in.out_word2 = {side.word2[31:16], csum};
         data_in.out_word3 = side.word3;
         data_in.out_word4 = side.word4;
      end else begin
         priority if (side.pre_status != ihc_pkg::ST_OK) begin
            data_in.status = side.pre_status;
         end else if (fold2[15:0] != ihc_pkg::CSUM_ONES) begin
            data_in.status = ihc_pkg::ST_CHECKSUM;
         end else if (side.dest_bad) begin
            data_in.status = ihc_pkg::ST_DEST;
         end else begin
            data_in.status         = ihc_pkg::ST_OK;
            data_in.payload_offset = side.payload_offset;
            data_in.payload_length = side.payload_length;
         end
      end
   end

   assign valid_in = valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### src/ipv4_header_check_and_build.sv
// Channel   Ports                                   Handshake
// request   start, busy, req_data                   beat taken when start && !busy
// response  rsp_valid, rsp_data                     one-cycle strobe, no back-pressure
// config    psel, penable, pwrite, paddr, pwdata,   APB, pready tied high
//           prdata, pready
//
// An accepted request is registered in the lane adders, then in the merge and fold, before its response strobe.
// One header per cycle; busy stays low, the five word lanes set the rate.
// Synchronous reset clears the pipeline valids and local_address.
// Responses cannot be stalled; every accepted beat yields exactly one response.
module ipv4_header_check_and_build (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ihc_pkg::req_type req_data,
   output logic             rsp_valid,
   output ihc_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [31:0]       local_addr_ff;
   logic [31:0]       local_addr_in;
   logic              valid_ff;
   logic              valid_in;
   ihc_pkg::side_type side_ff;
   ihc_pkg::side_type side_in;

   logic [31:0] built0;
   logic [31:0] built2;
   logic [31:0] lane_word [ihc_pkg::NUM_LANES];
   logic [16:0] lane_sum  [ihc_pkg::NUM_LANES];
   logic [3:0]  ihl;
   logic [5:0]  offset;
   logic [15:0] off_ext;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   always_comb begin
      local_addr_in = local_addr_ff;
      if (psel && penable && pwrite && !paddr[2]) begin
         local_addr_in = pwdata;
      end
   end

   assign prdata = paddr[2] ? 32'd0 : local_addr_ff;

   assign built0 = {ihc_pkg::VER_IHL, 8'h00, req_data.packet_length + ihc_pkg::HDR_BYTES};
   assign built2 = {req_data.ttl, req_data.protocol, 16'h0000};

   always_comb begin
      if (req_data.func) begin
         lane_word[0] = built0;
         lane_word[1] = 32'd0;
         lane_word[2] = built2;
         lane_word[3] = req_data.src_addr;
         lane_word[4] = req_data.dst_addr;
      end else begin
         lane_word[0] = req_data.hdr_word0;
         lane_word[1] = req_data.hdr_word1;
         lane_word[2] = req_data.hdr_word2;
         lane_word[3] = req_data.hdr_word3;
         lane_word[4] = req_data.hdr_word4;
      end
   end

   for (genvar g = 0; g < ihc_pkg::NUM_LANES; g++) begin : g_lane
      ihc_lane u_lane (
         .clock (clock),
         .word  (lane_word[g]),
         .sum   (lane_sum[g])
      );
   end

   assign ihl     = req_data.hdr_word0[27:24];
   assign offset  = {ihl, 2'b00};
   assign off_ext = {10'd0, offset};

   always_comb begin
      side_in                = '0;
      side_in.func           = req_data.func;
      side_in.payload_offset = offset;
      side_in.payload_length = (req_data.packet_length > off_ext)
                               ? (req_data.packet_length - off_ext) : 16'd0;
      side_in.dest_bad       = (req_data.hdr_word4 != local_addr_ff) &&
                               (req_data.hdr_word4 != (local_addr_ff | ihc_pkg::BCAST_MASK));
      priority if (req_data.hdr_word0[31:28] != ihc_pkg::IP_VERSION) begin
         side_in.pre_status = ihc_pkg::ST_VERSION;
      end else if (ihl < ihc_pkg::MIN_IHL) begin
         side_in.pre_status = ihc_pkg::ST_HEADLEN;
      end else if (req_data.hdr_word2[31:24] == 8'd0) begin
         side_in.pre_status = ihc_pkg::ST_TTL;
      end else begin
         side_in.pre_status = ihc_pkg::ST_OK;
      end
      side_in.word0 = built0;
      side_in.word1 = 32'd0;
      side_in.word2 = built2;
      side_in.word3 = req_data.src_addr;
      side_in.word4 = req_data.dst_addr;
   end

   assign valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         local_addr_ff <= 32'd0;
         valid_ff      <= 1'b0;
      end else begin
         local_addr_ff <= local_addr_in;
         valid_ff      <= valid_in;
      end
      side_ff <= side_in;
   end

   ihc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .valid     (valid_ff),
      .lane_sum  (lane_sum),
      .side      (side_ff),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

### src/ihc_checker.sv
module ihc_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input ihc_pkg::rsp_type rsp_data
);

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted beat produced no response");

   a_no_phantom: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 2))
      else $error("response without accepted beat");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status <= ihc_pkg::ST_DEST))
      else $error("status code out of range");

   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ihc_pkg::ST_OK) |->
      (rsp_data.out_word0 == 32'd0 && rsp_data.payload_length == 16'd0 &&
       rsp_data.payload_offset == 6'd0))
      else $error("failed check carries payload fields");

endmodule

bind ipv4_header_check_and_build ihc_checker u_ihc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);
